### hw/rtl/mqlm_pkg.sv
// mqlm_pkg: shared types and codes of the multi-queue link manager
`timescale 1ns / 1ps

package mqlm_pkg;

    // fixed field widths of the beat payloads
    localparam int KIND_W = 2;
    localparam int QID_W  = 4;
    localparam int ELEM_W = 6;
    localparam int POS_W  = 6;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DRAIN  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [QID_W-1:0]  queue_id;
        logic [ELEM_W-1:0] element_id;
    } t_in_item;

    typedef struct packed {
        logic [POS_W-1:0]  position;
        logic [ELEM_W-1:0] out_element;
        logic              empty_res;
        logic              last;
    } t_out_item;

    // sequencer status seen by the top level
    typedef struct packed {
        logic sweeping;
        logic walking;
    } t_seq_status;

endpackage

### hw/rtl/mqlm_if.sv
// mqlm_if: valid/ready channel interfaces for command and result beats
`timescale 1ns / 1ps

interface mqlm_in_if;
    import mqlm_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface mqlm_out_if;
    import mqlm_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### hw/rtl/mqlm_ram.sv
// mqlm_ram: single-port-write, single-port-read memory with registered read data
`timescale 1ns / 1ps

module mqlm_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hw/rtl/mqlm_seq.sv
// mqlm_seq: command sequencer, queue table update, link walk and result register
`timescale 1ns / 1ps

module mqlm_seq #(
    parameter int NUM_QUEUES   = 16,
    parameter int NUM_ELEMENTS = 64,
    localparam int QW  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1,
    localparam int EW  = $clog2(NUM_ELEMENTS),
    localparam int LW  = $clog2(NUM_ELEMENTS + 1),
    localparam int QEW = EW + LW
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    mqlm_in_if.sink              i_in,
    mqlm_out_if.source           o_out,
    // queue table memory
    output logic                 o_qt_wr_en,
    output logic [QW-1:0]        o_qt_wr_addr,
    output logic [QEW-1:0]       o_qt_wr_data,
    output logic                 o_qt_rd_en,
    output logic [QW-1:0]        o_qt_rd_addr,
    input  logic [QEW-1:0]       i_qt_rd_data,
    // link memory
    output logic                 o_lk_wr_en,
    output logic [EW-1:0]        o_lk_wr_addr,
    output logic [EW-1:0]        o_lk_wr_data,
    output logic                 o_lk_rd_en,
    output logic [EW-1:0]        o_lk_rd_addr,
    input  logic [EW-1:0]        i_lk_rd_data,
    output mqlm_pkg::t_seq_status o_status
);
    import mqlm_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_LOOK  = 4'b0100,
        S_WALK  = 4'b1000
    } t_state;

    t_state    r_state, n_state;
    logic [QW-1:0] r_sweep, n_sweep;
    logic      r_out_valid, n_out_valid;

    logic      r_is_drain, n_is_drain;
    logic      r_qok, n_qok;
    logic [QW-1:0] r_qidx, n_qidx;
    logic [EW-1:0] r_elem, n_elem;
    logic [EW-1:0] r_pos, n_pos;
    logic [EW-1:0] r_cur, n_cur;
    logic      r_use_link, n_use_link;
    logic      r_empty, n_empty;
    t_out_item r_out, n_out;

    logic          in_fire;
    logic          q_ok;
    logic          e_ok;
    logic          out_free;
    logic          emit;
    t_out_item     item;
    logic [LW-1:0] qt_len;
    logic [EW-1:0] qt_tail;
    logic [EW-1:0] cur_elem;

    assign in_fire  = i_in.valid && i_in.ready;
    assign q_ok     = 32'(i_in.payload.queue_id) < 32'(NUM_QUEUES);
    assign e_ok     = 32'(i_in.payload.element_id) < 32'(NUM_ELEMENTS);
    assign out_free = !r_out_valid || o_out.ready;
    assign qt_len   = i_qt_rd_data[LW-1:0];
    assign qt_tail  = i_qt_rd_data[QEW-1:LW];
    assign cur_elem = r_use_link ? i_lk_rd_data : r_cur;

    assign i_in.ready    = (r_state == S_IDLE);
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    assign o_status.sweeping = (r_state == S_CLEAR);
    assign o_status.walking  = (r_state == S_WALK);

    always_comb begin
        n_state      = r_state;
        n_sweep      = r_sweep;
        n_is_drain   = r_is_drain;
        n_qok        = r_qok;
        n_qidx       = r_qidx;
        n_elem       = r_elem;
        n_pos        = r_pos;
        n_cur        = r_cur;
        n_use_link   = r_use_link;
        n_empty      = r_empty;
        emit         = 1'b0;
        item         = '0;
        o_qt_wr_en   = 1'b0;
        o_qt_wr_addr = r_qidx;
        o_qt_wr_data = '0;
        o_qt_rd_en   = 1'b0;
        o_qt_rd_addr = QW'(i_in.payload.queue_id);
        o_lk_wr_en   = 1'b0;
        o_lk_wr_addr = r_elem;
        o_lk_wr_data = qt_tail;
        o_lk_rd_en   = 1'b0;
        o_lk_rd_addr = cur_elem;

        unique case (r_state)
            S_CLEAR: begin
                // zero one queue length per cycle
                o_qt_wr_en   = 1'b1;
                o_qt_wr_addr = r_sweep;
                if (r_sweep == QW'(NUM_QUEUES - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_sweep = r_sweep + 1'b1;
                end
            end
            S_IDLE: begin
                if (in_fire) begin
                    unique case (i_in.payload.kind)
                        KIND_APPEND: begin
                            if (q_ok && e_ok) begin
                                o_qt_rd_en = 1'b1;
                                n_is_drain = 1'b0;
                                n_qidx     = QW'(i_in.payload.queue_id);
                                n_elem     = EW'(i_in.payload.element_id);
                                n_state    = S_LOOK;
                            end
                        end
                        KIND_DRAIN: begin
                            o_qt_rd_en = q_ok;
                            n_is_drain = 1'b1;
                            n_qok      = q_ok;
                            n_state    = S_LOOK;
                        end
                        KIND_CLEAR: begin
                            n_sweep = '0;
                            n_state = S_CLEAR;
                        end
                        default: ;
                    endcase
                end
            end
            S_LOOK: begin
                if (r_is_drain) begin
                    n_cur      = qt_tail;
                    n_use_link = 1'b0;
                    if (!r_qok || qt_len == '0) begin
                        n_empty = 1'b1;
                        n_pos   = '0;
                    end else begin
                        n_empty = 1'b0;
                        n_pos   = EW'(qt_len - LW'(1));
                    end
                    n_state = S_WALK;
                end else begin
                    // full queue drops the append
                    if (qt_len < LW'(NUM_ELEMENTS)) begin
                        o_lk_wr_en   = (qt_len != '0);
                        o_qt_wr_en   = 1'b1;
                        o_qt_wr_data = {r_elem, LW'(qt_len + LW'(1))};
                    end
                    n_state = S_IDLE;
                end
            end
            S_WALK: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (r_empty) begin
                        item.empty_res = 1'b1;
                        item.last      = 1'b1;
                        n_state        = S_IDLE;
                    end else begin
                        item.position    = POS_W'(r_pos);
                        item.out_element = ELEM_W'(cur_elem);
                        item.last        = (r_pos == '0);
                        if (r_pos == '0) begin
                            n_state = S_IDLE;
                        end else begin
                            // fetch the predecessor while this beat goes out
                            o_lk_rd_en = 1'b1;
                            n_pos      = r_pos - 1'b1;
                            n_cur      = cur_elem;
                            n_use_link = 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (emit) begin
            n_out_valid = 1'b1;
            n_out       = item;
        end else begin
            n_out_valid = r_out_valid && !o_out.ready;
            n_out       = r_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_sweep     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sweep     <= n_sweep;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_is_drain <= n_is_drain;
        r_qok      <= n_qok;
        r_qidx     <= n_qidx;
        r_elem     <= n_elem;
        r_pos      <= n_pos;
        r_cur      <= n_cur;
        r_use_link <= n_use_link;
        r_empty    <= n_empty;
        r_out      <= n_out;
    end

endmodule

### hw/rtl/multi_queue_link_manager_core.sv
// multi_queue_link_manager_core: top level of the linked-list queue manager
`timescale 1ns / 1ps

// channel   dir  beat payload                              accepted when
// i_in      in   kind, queue_id, element_id                valid && ready
// o_out     out  position, out_element, empty_res, last    valid && ready
//
// steps: an append reads the queue table, then writes the table back and, onto a
//   nonempty queue, the link; a drain reads the table, then emits one beat per
//   element, reading the link memory for each element after the tail (an empty
//   queue gives one beat); a clear sweeps the table; kind 3 and out-of-range appends are dropped
// reset: synchronous, active low; afterwards the queue table is swept to
//   zero, one entry per cycle, with i_in.ready low until the sweep is done
// stalls: o_out has a one-beat output register; a drain waits there while
//   o_out.ready is low, and a new command is taken while the last beat waits

module multi_queue_link_manager_core #(
    parameter int NUM_QUEUES   = 16,
    parameter int NUM_ELEMENTS = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mqlm_in_if.sink    i_in,
    mqlm_out_if.source o_out
);
    import mqlm_pkg::*;

    localparam int QW  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int EW  = $clog2(NUM_ELEMENTS);
    localparam int LW  = $clog2(NUM_ELEMENTS + 1);
    localparam int QEW = EW + LW;

    // queue table port: {tail, length} per queue
    logic           qt_wr_en;
    logic [QW-1:0]  qt_wr_addr;
    logic [QEW-1:0] qt_wr_data;
    logic           qt_rd_en;
    logic [QW-1:0]  qt_rd_addr;
    logic [QEW-1:0] qt_rd_data;

    // link memory port: predecessor of each element
    logic          lk_wr_en;
    logic [EW-1:0] lk_wr_addr;
    logic [EW-1:0] lk_wr_data;
    logic          lk_rd_en;
    logic [EW-1:0] lk_rd_addr;
    logic [EW-1:0] lk_rd_data;

    t_seq_status status;

    // sequencer owns all control; the two memories hold all queue state
    mqlm_seq #(
        .NUM_QUEUES   (NUM_QUEUES),
        .NUM_ELEMENTS (NUM_ELEMENTS)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_out        (o_out),
        .o_qt_wr_en   (qt_wr_en),
        .o_qt_wr_addr (qt_wr_addr),
        .o_qt_wr_data (qt_wr_data),
        .o_qt_rd_en   (qt_rd_en),
        .o_qt_rd_addr (qt_rd_addr),
        .i_qt_rd_data (qt_rd_data),
        .o_lk_wr_en   (lk_wr_en),
        .o_lk_wr_addr (lk_wr_addr),
        .o_lk_wr_data (lk_wr_data),
        .o_lk_rd_en   (lk_rd_en),
        .o_lk_rd_addr (lk_rd_addr),
        .i_lk_rd_data (lk_rd_data),
        .o_status     (status)
    );

    // length and tail per queue, swept to zero length on reset and clear
    mqlm_ram #(
        .DEPTH (NUM_QUEUES),
        .WIDTH (QEW)
    ) u_queue_table (
        .i_clk     (i_clk),
        .i_wr_en   (qt_wr_en),
        .i_wr_addr (qt_wr_addr),
        .i_wr_data (qt_wr_data),
        .i_rd_en   (qt_rd_en),
        .i_rd_addr (qt_rd_addr),
        .o_rd_data (qt_rd_data)
    );

    // backward links, shared by all queues, never cleared
    mqlm_ram #(
        .DEPTH (NUM_ELEMENTS),
        .WIDTH (EW)
    ) u_link_mem (
        .i_clk     (i_clk),
        .i_wr_en   (lk_wr_en),
        .i_wr_addr (lk_wr_addr),
        .i_wr_data (lk_wr_data),
        .i_rd_en   (lk_rd_en),
        .i_rd_addr (lk_rd_addr),
        .o_rd_data (lk_rd_data)
    );

    // no command taken during the table sweep or a link walk
    a_busy_blocks_input: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (status.sweeping || status.walking) |-> !i_in.ready
    ) else $error("command accepted while sweeping or walking");

    // an empty-queue beat is the only beat of its drain, at position zero
    a_empty_beat_shape: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.payload.empty_res) |->
            (o_out.payload.last && o_out.payload.position == '0)
    ) else $error("empty result beat without last or at nonzero position");

    // a beat before the final one belongs to a drain still in progress
    a_mid_drain_beat: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.payload.last) |->
            (o_out.payload.position != '0 && !o_out.payload.empty_res && !i_in.ready)
    ) else $error("inconsistent non-final drain beat");

    // the walk only reads the link memory while it emits a beat
    a_link_read_in_walk: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        lk_rd_en |-> (status.walking && !(o_out.valid && !o_out.ready))
    ) else $error("link read outside an advancing walk");

endmodule
